// ===== rtl/pttm_pkg.sv =====
// Shared types, constants and the fixed binding table of the pad to touch event mapper.
// No dependencies; compile first.
package pttm_pkg;

	localparam int          NUM_BINDINGS_DEF = 7;
	localparam int          BIND_MAX         = 16;
	localparam logic [6:0]  PTR_BASE         = 7'd64;
	localparam logic [11:0] WIDTH_RST        = 12'd1280;
	localparam logic [11:0] HEIGHT_RST       = 12'd720;
	localparam logic [14:0] DEAD_ZONE_RST    = 15'd5898;
	localparam int          CFG_DW           = 15;

	typedef enum logic [1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_DEAD_ZONE     = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_DOWN = 2'd0,
		PH_MOVE = 2'd1,
		PH_UP   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BUTTON = 2'd0,
		KIND_LEFT   = 2'd1,
		KIND_RIGHT  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  sel;
		logic [15:0] fx;
		logic [15:0] fy;
	} bind_t;

	typedef struct packed {
		logic [4:0] buttons;
		logic       left;
		logic       right;
		logic       silent;
	} lane_in_t;

	typedef struct packed {
		logic        act;
		phase_t      phase;
		logic [15:0] x;
		logic [15:0] y;
	} lane_evt_t;

	function automatic bind_t bind_entry(input logic [3:0] k);
		bind_t b;
		case (k)
			4'd0:    b = '{KIND_BUTTON, 3'd0, 16'd53556, 16'd61256};
			4'd1:    b = '{KIND_BUTTON, 3'd1, 16'd58727, 16'd53700};
			4'd2:    b = '{KIND_BUTTON, 3'd2, 16'd47972, 16'd61440};
			4'd3:    b = '{KIND_LEFT,   3'd0, 16'd5885,  16'd58707};
			4'd4:    b = '{KIND_RIGHT,  3'd0, 16'd13055, 16'd58707};
			4'd5:    b = '{KIND_BUTTON, 3'd3, 16'd5885,  16'd5459};
			4'd6:    b = '{KIND_BUTTON, 3'd4, 16'd9470,  16'd5459};
			default: b = '{KIND_NONE,   3'd0, 16'd0,     16'd0};
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/pttm_if.sv =====
// Valid/ready channel interfaces for pad items in and touch event items out.
// No dependencies.
interface pttm_in_if;
	logic               valid;
	logic               ready;
	logic [4:0]         button_bits;
	logic signed [15:0] stick_x;
	logic signed [15:0] stick_y;
	logic               cursor_shown;
	logic [2:0]         room;

	modport source (output valid, button_bits, stick_x, stick_y, cursor_shown, room,
		input ready);
	modport sink (input valid, button_bits, stick_x, stick_y, cursor_shown, room,
		output ready);
endinterface

interface pttm_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  pointer_id;
	logic [15:0] touch_x;
	logic [15:0] touch_y;
	logic [1:0]  phase;
	logic        last;

	modport source (output valid, pointer_id, touch_x, touch_y, phase, last, input ready);
	modport sink (input valid, pointer_id, touch_x, touch_y, phase, last, output ready);
endinterface

// ===== rtl/pad_to_touch_event_mapper_top.sv =====
// Pad to touch event mapper: input register, stick decode, binding lanes, merge stage.
// Depends on pttm_pkg, pttm_if, pttm_lane, pttm_merge.
//
// Usage: the pad channel takes one item per display frame (buttons, left stick,
// cursor flag and room). The touch channel returns zero to seven event items for it,
// in binding order, with last set on the final one. A frame that emits nothing
// returns no item.
// Configuration: cfg_we, cfg_idx and cfg_data write screen width, screen height and
// dead zone. The user must write them only while the block is idle; the block does
// not enforce this. Scaled positions are registered from the written values. The
// first event of a frame passes the input register, merge buffer and output register.
// Throughput: one event item per cycle out of the merge buffer while touch.ready
// allows; a new pad item is accepted while the previous frame drains its last event.
// Reset: held state clears, registers return to 1280 x 720 and dead zone 5898,
// no item is pending.
// Stall: when touch.ready is low the output register holds its item, the merge
// buffer holds the rest of the frame, and pad.ready drops once the input register
// is full while the merge buffer still holds events.
module pad_to_touch_event_mapper_top #(
	parameter int NUM_BINDINGS = pttm_pkg::NUM_BINDINGS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pttm_in_if.sink                   pad,
	pttm_out_if.source                touch,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [pttm_pkg::CFG_DW-1:0] cfg_data
);
	import pttm_pkg::*;

	logic [11:0]        width_q;
	logic [11:0]        height_q;
	logic [14:0]        dead_zone_q;
	logic               valid_s1;
	logic [4:0]         buttons_s1;
	logic signed [15:0] sx_s1;
	logic signed [15:0] sy_s1;
	logic               silent_s1;
	logic [2:0]         room_s1;
	logic [15:0]        ax;
	logic [15:0]        ay;
	logic               dom;
	lane_in_t           lin;
	lane_evt_t          evt [NUM_BINDINGS];
	logic               take;
	logic [NUM_BINDINGS-1:0] emit;
	logic               blank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			dead_zone_q <= DEAD_ZONE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SCREEN_WIDTH:  width_q     <= cfg_data[11:0];
				CFG_SCREEN_HEIGHT: height_q    <= cfg_data[11:0];
				CFG_DEAD_ZONE:     dead_zone_q <= cfg_data[14:0];
				default:           ;
			endcase
		end
	end

	assign pad.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pad.ready) begin
			valid_s1 <= pad.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pad.valid && pad.ready) begin
			buttons_s1 <= pad.button_bits;
			sx_s1      <= pad.stick_x;
			sy_s1      <= pad.stick_y;
			silent_s1  <= pad.cursor_shown;
			room_s1    <= pad.room;
		end
	end

	assign ax  = sx_s1[15] ? 16'(-sx_s1) : 16'(sx_s1);
	assign ay  = sy_s1[15] ? 16'(-sy_s1) : 16'(sy_s1);
	assign dom = ax >= ay;

	always_comb begin
		lin.buttons = buttons_s1;
		lin.left    = sx_s1[15] && (ax > {1'b0, dead_zone_q}) && dom;
		lin.right   = !sx_s1[15] && (ax > {1'b0, dead_zone_q}) && dom;
		lin.silent  = silent_s1;
	end

	assign blank = (width_q == '0) || (height_q == '0);

	for (genvar i = 0; i < NUM_BINDINGS; i++) begin : g_lane
		pttm_lane #(
			.IDX(i)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.screen_width (width_q),
			.screen_height(height_q),
			.lin          (lin),
			.commit       (take && emit[i]),
			.evt          (evt[i])
		);
	end

	pttm_merge #(
		.NB(NUM_BINDINGS)
	) u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (valid_s1),
		.room  (room_s1),
		.blank (blank),
		.evt   (evt),
		.take  (take),
		.emit  (emit),
		.touch (touch)
	);

endmodule

// ===== rtl/pttm_lane.sv =====
// One binding lane: fire decision, scaled position, held state and event kind.
// Depends on pttm_pkg.
module pttm_lane #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [11:0]         screen_width,
	input  logic [11:0]         screen_height,
	input  pttm_pkg::lane_in_t  lin,
	input  logic                commit,
	output pttm_pkg::lane_evt_t evt
);
	import pttm_pkg::*;

	localparam bind_t B = bind_entry(4'(IDX));

	logic [27:0] prod_x;
	logic [27:0] prod_y;
	logic [15:0] pos_x_q;
	logic [15:0] pos_y_q;
	logic        held_q;
	logic [15:0] held_x_q;
	logic [15:0] held_y_q;
	logic        fired;

	assign prod_x = 28'(B.fx) * 28'(screen_width);
	assign prod_y = 28'(B.fy) * 28'(screen_height);

	always_ff @(posedge clk) begin
		pos_x_q <= prod_x[27:12];
		pos_y_q <= prod_y[27:12];
	end

	always_comb begin
		case (B.kind)
			KIND_BUTTON: fired = lin.buttons[B.sel];
			KIND_LEFT:   fired = lin.left;
			KIND_RIGHT:  fired = lin.right;
			default:     fired = 1'b0;
		endcase
		if (lin.silent) begin
			fired = 1'b0;
		end

		evt = '{1'b0, PH_MOVE, pos_x_q, pos_y_q};
		if (fired && !held_q) begin
			evt.act   = 1'b1;
			evt.phase = PH_DOWN;
		end else if (!fired && held_q) begin
			evt = '{1'b1, PH_UP, held_x_q, held_y_q};
		end else if (fired && (pos_x_q != held_x_q || pos_y_q != held_y_q)) begin
			evt.act = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (commit) begin
			if (evt.phase == PH_UP) begin
				held_q <= 1'b0;
			end else begin
				held_q   <= 1'b1;
				held_x_q <= pos_x_q;
				held_y_q <= pos_y_q;
			end
		end
	end

endmodule

// ===== rtl/pttm_merge.sv =====
// Merge stage: picks a frame's first room events, buffers them, sends them out through
// an output register, one item per cycle unless stalled. Depends on pttm_pkg, pttm_if.
module pttm_merge #(
	parameter int NB = pttm_pkg::NUM_BINDINGS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  logic [2:0]          room,
	input  logic                blank,
	input  pttm_pkg::lane_evt_t evt [NB],
	output logic                take,
	output logic [NB-1:0]       emit,
	pttm_out_if.source          touch
);
	import pttm_pkg::*;

	logic [NB-1:0] act;
	logic [NB-1:0] lm;
	logic [NB-1:0] mask_s2;
	logic [NB-1:0] onehot;
	logic [NB-1:0] rest;
	logic [15:0]   x_s2 [NB];
	logic [15:0]   y_s2 [NB];
	phase_t        ph_s2 [NB];
	logic          move;
	logic [6:0]    sel_id;
	logic [15:0]   sel_x;
	logic [15:0]   sel_y;
	phase_t        sel_ph;
	logic          out_valid_q;
	logic [6:0]    out_id_q;
	logic [15:0]   out_x_q;
	logic [15:0]   out_y_q;
	phase_t        out_ph_q;
	logic          out_last_q;

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			act[i] = evt[i].act && !blank;
		end
		for (int i = 0; i < NB; i++) begin
			lm      = (NB'(1) << i) - NB'(1);
			emit[i] = act[i] && ($countones(act & lm) < int'(room));
		end
	end

	assign onehot = mask_s2 & (~mask_s2 + NB'(1));
	assign rest   = mask_s2 & ~onehot;
	assign move   = (mask_s2 != '0) && (!out_valid_q || touch.ready);
	assign take   = valid && ((mask_s2 == '0) || (move && rest == '0));

	always_comb begin
		sel_id = PTR_BASE;
		sel_x  = '0;
		sel_y  = '0;
		sel_ph = PH_DOWN;
		for (int i = 0; i < NB; i++) begin
			if (onehot[i]) begin
				sel_id = 7'(PTR_BASE + 7'(i));
				sel_x  = x_s2[i];
				sel_y  = y_s2[i];
				sel_ph = ph_s2[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (take) begin
			mask_s2 <= emit;
		end else if (move) begin
			mask_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < NB; i++) begin
				x_s2[i]  <= evt[i].x;
				y_s2[i]  <= evt[i].y;
				ph_s2[i] <= evt[i].phase;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (touch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_id_q   <= sel_id;
			out_x_q    <= sel_x;
			out_y_q    <= sel_y;
			out_ph_q   <= sel_ph;
			out_last_q <= (rest == '0);
		end
	end

	assign touch.valid      = out_valid_q;
	assign touch.pointer_id = out_id_q;
	assign touch.touch_x    = out_x_q;
	assign touch.touch_y    = out_y_q;
	assign touch.phase      = out_ph_q;
	assign touch.last       = out_last_q;

endmodule

// ===== rtl/pttm_check.sv =====
// Port-level checks on the touch channel of the mapper, bound to the top level.
// Depends on pttm_pkg and pad_to_touch_event_mapper_top.
module pttm_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  out_id,
	input logic [15:0] out_x,
	input logic [15:0] out_y,
	input logic [1:0]  out_phase,
	input logic        out_last
);
	import pttm_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_x)
			&& $stable(out_y) && $stable(out_phase) && $stable(out_last))
		else $error("touch item changed while stalled");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_phase == PH_DOWN || out_phase == PH_MOVE || out_phase == PH_UP))
		else $error("illegal touch phase");

	a_pointer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_id[6:4] == PTR_BASE[6:4])
		else $error("pointer id outside synthetic range");

	a_id_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last ##1 out_valid |-> out_id > $past(out_id))
		else $error("events of one frame out of binding order");

endmodule

bind pad_to_touch_event_mapper_top pttm_check u_pttm_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(touch.valid),
	.out_ready(touch.ready),
	.out_id   (touch.pointer_id),
	.out_x    (touch.touch_x),
	.out_y    (touch.touch_y),
	.out_phase(touch.phase),
	.out_last (touch.last)
);
